@@ design/id3fx_pkg.sv @@
// Package for the ID3 frame extractor: shared types, register indexes and codes.
// No dependencies; imported by every module of the block.
package id3fx_pkg;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICTURE_MODE = 2'd1;
    localparam logic [31:0] TARGET_ID_RESET = 32'h4150_4943;  // "APIC"

    // Tag and frame header constants
    localparam logic [23:0] ID3_MARK     = 24'h49_4433;      // "ID3"
    localparam logic [7:0]  ID3_VERSION  = 8'd3;
    localparam logic [3:0]  HDR_LAST_POS = 4'd9;              // tenth header byte
    localparam logic [32:0] HDR_BYTES    = 33'd10;
    localparam logic [6:0]  SYNCSAFE_MASK = 7'h7F;

    // Result outcome codes
    typedef enum logic [2:0] {
        OC_RUNNING   = 3'd0,
        OC_FOUND     = 3'd1,
        OC_NO_TAG    = 3'd2,
        OC_BAD_VER   = 3'd3,
        OC_NOT_FOUND = 3'd4,
        OC_TRUNCATED = 3'd5,
        OC_EMPTY     = 3'd6
    } t_outcome;

    // Parser phase
    typedef enum logic [3:0] {
        PH_TAG_HEADER   = 4'b0001,
        PH_FRAME_HEADER = 4'b0010,
        PH_SKIP         = 4'b0100,
        PH_PICTURE      = 4'b1000
    } t_phase;

    // Picture frame field walk
    typedef enum logic [4:0] {
        SUB_ENCODING    = 5'b00001,
        SUB_MIME        = 5'b00010,
        SUB_TYPE        = 5'b00100,
        SUB_DESCRIPTION = 5'b01000,
        SUB_PAYLOAD     = 5'b10000
    } t_sub_phase;

    // One input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_end;
    } t_in_item;

    // One result transaction, plus whether the byte produces one at all
    typedef struct packed {
        logic       emit;
        logic [7:0] picture_byte;
        logic       picture_valid;
        logic       picture_last;
        logic       finished;
        t_outcome   outcome;
    } t_result;

endpackage

@@ design/id3fx_in_stage.sv @@
// Input register of the ID3 frame extractor: captures one byte transaction.
// Depends on id3fx_pkg.
module id3fx_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  id3fx_pkg::t_in_item i_item,
    input  logic                i_advance,
    output logic                o_item_valid,
    output id3fx_pkg::t_in_item o_item
);
    import id3fx_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    // Hold the stored byte while the parser cannot advance
    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance || !r_valid) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

@@ design/id3fx_parser.sv @@
// Tag and frame parser of the ID3 frame extractor: configuration registers,
// parse state and the per-byte decision logic. Depends on id3fx_pkg.
module id3fx_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [id3fx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [id3fx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_go,
    input  id3fx_pkg::t_in_item            i_item,
    output id3fx_pkg::t_result             o_result
);
    import id3fx_pkg::*;

    // Configuration
    logic [31:0] r_target_id;
    logic        r_picture_mode;

    // Parse state
    t_phase      r_phase, n_phase;
    t_sub_phase  r_sub, n_sub;
    logic [3:0]  r_pos, n_pos;
    logic [27:0] r_tag_len, n_tag_len;
    logic [32:0] r_consumed, n_consumed;
    logic [31:0] r_fid, n_fid;
    logic [31:0] r_flen, n_flen;
    logic [31:0] r_left, n_left;

    logic        done, pic_valid, pic_last;
    t_outcome    oc;
    logic [32:0] skip_total;
    logic [7:0]  b;

    assign b = i_item.data_byte;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id    <= TARGET_ID_RESET;
            r_picture_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET_ID:    r_target_id    <= i_cfg_data;
                CFG_PICTURE_MODE: r_picture_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Bytes consumed once a non-matching frame is skipped
    assign skip_total = r_consumed + HDR_BYTES + {1'b0, r_flen};

    // Per-byte decision
    always_comb begin
        n_phase    = r_phase;
        n_sub      = r_sub;
        n_pos      = r_pos;
        n_tag_len  = r_tag_len;
        n_consumed = r_consumed;
        n_fid      = r_fid;
        n_flen     = r_flen;
        n_left     = r_left;
        done       = 1'b0;
        pic_valid  = 1'b0;
        pic_last   = 1'b0;
        oc         = OC_RUNNING;

        if (i_go) begin
            unique case (r_phase)
                PH_FRAME_HEADER: begin
                    if (r_pos == 4'd0 && b == 8'd0) begin
                        // padding where a frame should start
                        done = 1'b1;
                        oc   = OC_NOT_FOUND;
                    end else begin
                        if (r_pos < 4'd4) begin
                            n_fid = {r_fid[23:0], b};
                        end else if (r_pos < 4'd8) begin
                            n_flen = {r_flen[23:0], b};
                        end
                        if (r_pos == HDR_LAST_POS) begin
                            n_pos = 4'd0;
                            if (r_fid == r_target_id) begin
                                if (!r_picture_mode) begin
                                    done = 1'b1;
                                    oc   = OC_FOUND;
                                end else if (r_flen == 32'd0) begin
                                    done = 1'b1;
                                    oc   = OC_EMPTY;
                                end else begin
                                    n_left  = r_flen;
                                    n_sub   = SUB_ENCODING;
                                    n_phase = PH_PICTURE;
                                end
                            end else begin
                                n_consumed = skip_total;
                                if (skip_total >= {5'd0, r_tag_len}) begin
                                    done = 1'b1;
                                    oc   = OC_NOT_FOUND;
                                end else if (r_flen != 32'd0) begin
                                    n_left  = r_flen;
                                    n_phase = PH_SKIP;
                                end
                            end
                        end else begin
                            n_pos = r_pos + 4'd1;
                        end
                    end
                end
                PH_SKIP: begin
                    n_left = r_left - 32'd1;
                    if (r_left == 32'd1) begin
                        n_phase = PH_FRAME_HEADER;
                        n_pos   = 4'd0;
                    end
                end
                PH_PICTURE: begin
                    n_left = r_left - 32'd1;
                    // drop the leading fields, one zero terminator per string
                    unique case (r_sub)
                        SUB_ENCODING: n_sub = SUB_MIME;
                        SUB_MIME: begin
                            if (b == 8'd0) n_sub = SUB_TYPE;
                        end
                        SUB_TYPE: n_sub = SUB_DESCRIPTION;
                        SUB_DESCRIPTION: begin
                            if (b == 8'd0) n_sub = SUB_PAYLOAD;
                        end
                        default: pic_valid = 1'b1;
                    endcase
                    if (r_left == 32'd1) begin
                        done     = 1'b1;
                        pic_last = pic_valid;
                        oc       = pic_valid ? OC_FOUND : OC_EMPTY;
                    end
                end
                default: begin
                    // tag header: marker and version, then syncsafe length
                    if (r_pos < 4'd4) begin
                        n_fid = {r_fid[23:0], b};
                    end else if (r_pos >= 4'd6) begin
                        n_tag_len = {r_tag_len[20:0], b[6:0] & SYNCSAFE_MASK};
                    end
                    if (r_pos == HDR_LAST_POS) begin
                        done = 1'b1;
                        if (r_fid[31:8] != ID3_MARK) begin
                            oc = OC_NO_TAG;
                        end else if (r_fid[7:0] != ID3_VERSION) begin
                            oc = OC_BAD_VER;
                        end else if (n_tag_len == 28'd0) begin
                            oc = OC_NOT_FOUND;
                        end else begin
                            done       = 1'b0;
                            n_phase    = PH_FRAME_HEADER;
                            n_pos      = 4'd0;
                            n_consumed = 33'd0;
                        end
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end
            endcase

            // early end of file
            if (!done && i_item.file_end) begin
                done = 1'b1;
                oc   = OC_TRUNCATED;
            end

            // restart for the next file
            if (done) begin
                n_phase    = PH_TAG_HEADER;
                n_sub      = SUB_ENCODING;
                n_pos      = 4'd0;
                n_consumed = 33'd0;
            end
        end
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG_HEADER;
            r_sub      <= SUB_ENCODING;
            r_pos      <= 4'd0;
            r_consumed <= 33'd0;
        end else begin
            r_phase    <= n_phase;
            r_sub      <= n_sub;
            r_pos      <= n_pos;
            r_consumed <= n_consumed;
        end
    end

    // Advance field shifters and counters; each is loaded before it is read
    always_ff @(posedge i_clk) begin
        r_tag_len <= n_tag_len;
        r_fid     <= n_fid;
        r_flen    <= n_flen;
        r_left    <= n_left;
    end

    // Result of this byte
    always_comb begin
        o_result.emit          = i_go && (done || pic_valid);
        o_result.picture_byte  = pic_valid ? b : 8'd0;
        o_result.picture_valid = pic_valid;
        o_result.picture_last  = pic_last;
        o_result.finished      = done;
        o_result.outcome       = oc;
    end

endmodule

@@ design/id3fx_out_stage.sv @@
// Result register of the ID3 frame extractor, with the stall back to the parser.
// Depends on id3fx_pkg.
module id3fx_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  id3fx_pkg::t_result i_result,
    output logic               o_advance,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_picture_byte,
    output logic               o_picture_valid,
    output logic               o_picture_last,
    output logic               o_finished,
    output logic [2:0]         o_outcome
);
    import id3fx_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held result leaves this cycle
    assign o_advance = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_result.emit) begin
            r_res <= i_result;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_picture_byte  = r_res.picture_byte;
    assign o_picture_valid = r_res.picture_valid;
    assign o_picture_last  = r_res.picture_last;
    assign o_finished      = r_res.finished;
    assign o_outcome       = r_res.outcome;

endmodule

@@ design/id3_frame_extractor.sv @@
// Top level of the ID3v2.3 frame extractor: input register, parser, result register.
// Depends on id3fx_pkg, id3fx_in_stage, id3fx_parser, id3fx_out_stage.
//
//   Channel  | Handshake                     | Carries
//   ---------+-------------------------------+----------------------------------------
//   input    | i_in_valid / o_in_stall       | i_data_byte, i_file_end
//   result   | o_out_valid / i_out_stall     | picture byte, valid, last, finished, outcome
//   config   | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One byte per clock while the result side does not stall. A byte accepted into the input
// register is parsed from there once the result register can take its result, and that
// result (if any) is registered there and offered on the result channel.
// The parser update, with its 33-bit consumed-bytes add, is combinational between them.
// Reset is synchronous and active low; the parser returns to the tag header and
// the registers take their reset values (target "APIC", picture mode on).
// A held result stalls the parser, which in turn stalls the input register.
module id3_frame_extractor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_file_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_picture_byte,
    output logic                            o_picture_valid,
    output logic                            o_picture_last,
    output logic                            o_finished,
    output logic [2:0]                      o_outcome,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [id3fx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [id3fx_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import id3fx_pkg::*;

    t_in_item in_item, held_item;
    logic     held_valid;
    logic     advance;
    t_result  result;

    // Registers are always writable
    assign o_cfg_ready = 1'b1;

    assign in_item.data_byte = i_data_byte;
    assign in_item.file_end  = i_file_end;

    id3fx_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_item       (in_item),
        .i_advance    (advance),
        .o_item_valid (held_valid),
        .o_item       (held_item)
    );

    id3fx_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_go        (held_valid && advance),
        .i_item      (held_item),
        .o_result    (result)
    );

    id3fx_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_result        (result),
        .o_advance       (advance),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_picture_byte  (o_picture_byte),
        .o_picture_valid (o_picture_valid),
        .o_picture_last  (o_picture_last),
        .o_finished      (o_finished),
        .o_outcome       (o_outcome)
    );

endmodule

@@ design/id3fx_checker.sv @@
// Port-level checks for the ID3 frame extractor, bound to the top level.
// Depends on id3fx_pkg and id3_frame_extractor.
module id3fx_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] o_picture_byte,
    input  logic       o_picture_valid,
    input  logic       o_picture_last,
    input  logic       o_finished,
    input  logic [2:0] o_outcome
);
    import id3fx_pkg::*;

    // A stalled result stays offered
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // A result carries a picture byte or concludes the file
    a_result_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_picture_valid || o_finished))
        else $error("empty result transaction");

    // The last picture byte concludes the file as found
    a_last_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_picture_last |->
            o_picture_valid && o_finished && o_outcome == OC_FOUND)
        else $error("picture_last without found conclusion");

    // Outcome and byte are zero when they carry nothing
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_finished || o_outcome == OC_RUNNING) &&
                        (o_picture_valid || o_picture_byte == 8'd0))
        else $error("outcome or byte set without meaning");

endmodule

bind id3_frame_extractor id3fx_checker u_id3fx_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench for id3_frame_extractor: sends tagged files byte by byte and checks every result.
// The results are predicted by a parser model kept in this file. Depends on id3fx_pkg and id3_frame_extractor.
module tb;
    import id3fx_pkg::*;

    localparam int unsigned ITEM_TOTAL  = 1150;
    localparam int unsigned IDLE_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT = 250000;

    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;

    typedef logic [7:0] t_u8_q[$];

    typedef struct packed {
        logic [7:0] pic_byte;
        logic       pic_valid;
        logic       pic_last;
        logic       done;
        t_outcome   outcome;
    } t_pic_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte;
    logic                  i_file_end;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [7:0]            o_picture_byte;
    logic                  o_picture_valid;
    logic                  o_picture_last;
    logic                  o_finished;
    logic [2:0]            o_outcome;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Register copies and parser state of the model
    logic [31:0] cfg_target_id;
    logic        cfg_picture_mode;
    t_phase      ps_phase;
    logic [3:0]  ps_pos;
    logic [27:0] ps_tag_len;
    logic [32:0] ps_consumed;
    logic [31:0] ps_id_shift;
    logic [31:0] ps_frame_len;
    logic [31:0] ps_left;
    t_sub_phase  ps_sub;

    t_pic_result expected_q[$];
    int unsigned bytes_sent;
    int unsigned err_cnt;
    bit          quiet;
    int unsigned tx_window_left;
    bit          tx_window_busy;

    id3_frame_extractor u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_file_end      (i_file_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_picture_byte  (o_picture_byte),
        .o_picture_valid (o_picture_valid),
        .o_picture_last  (o_picture_last),
        .o_finished      (o_finished),
        .o_outcome       (o_outcome),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void restart_parser();
        ps_phase     = PH_TAG_HEADER;
        ps_pos       = 4'd0;
        ps_tag_len   = 28'd0;
        ps_consumed  = 33'd0;
        ps_id_shift  = 32'd0;
        ps_frame_len = 32'd0;
        ps_left      = 32'd0;
        ps_sub       = SUB_ENCODING;
    endfunction

    // Advance the parser by one file byte; returns 1 when the byte yields a result
    function automatic bit parse_byte(input logic [7:0] b, input logic at_end,
                                      output t_pic_result r);
        bit       done;
        bit       valid;
        bit       last;
        t_outcome oc;
        done  = 1'b0;
        valid = 1'b0;
        last  = 1'b0;
        oc    = OC_RUNNING;
        case (ps_phase)
            PH_TAG_HEADER: begin
                if (ps_pos < 4'd4)
                    ps_id_shift = {ps_id_shift[23:0], b};
                else if (ps_pos >= 4'd6)
                    ps_tag_len = {ps_tag_len[20:0], b[6:0]};
                if (ps_pos >= HDR_LAST_POS) begin
                    done = 1'b1;
                    if (ps_id_shift[31:8] != ID3_MARK)
                        oc = OC_NO_TAG;
                    else if (ps_id_shift[7:0] != ID3_VERSION)
                        oc = OC_BAD_VER;
                    else if (ps_tag_len == 28'd0)
                        oc = OC_NOT_FOUND;
                    else begin
                        done        = 1'b0;
                        ps_phase    = PH_FRAME_HEADER;
                        ps_pos      = 4'd0;
                        ps_consumed = 33'd0;
                        ps_id_shift = 32'd0;
                    end
                end else begin
                    ps_pos++;
                end
            end
            PH_FRAME_HEADER: begin
                if (ps_pos == 4'd0 && b == 8'd0) begin
                    // padding where a frame ID should start
                    done = 1'b1;
                    oc   = OC_NOT_FOUND;
                end else begin
                    if (ps_pos < 4'd4)
                        ps_id_shift = {ps_id_shift[23:0], b};
                    else if (ps_pos < 4'd8)
                        ps_frame_len = {ps_frame_len[23:0], b};
                    if (ps_pos >= HDR_LAST_POS) begin
                        ps_consumed = ps_consumed + HDR_BYTES;
                        ps_pos      = 4'd0;
                        if (ps_id_shift == cfg_target_id) begin
                            if (!cfg_picture_mode) begin
                                done = 1'b1;
                                oc   = OC_FOUND;
                            end else if (ps_frame_len == 32'd0) begin
                                done = 1'b1;
                                oc   = OC_EMPTY;
                            end else begin
                                ps_left  = ps_frame_len;
                                ps_sub   = SUB_ENCODING;
                                ps_phase = PH_PICTURE;
                            end
                        end else begin
                            ps_consumed = ps_consumed + {1'b0, ps_frame_len};
                            if (ps_consumed >= {5'd0, ps_tag_len}) begin
                                done = 1'b1;
                                oc   = OC_NOT_FOUND;
                            end else if (ps_frame_len != 32'd0) begin
                                ps_left  = ps_frame_len;
                                ps_phase = PH_SKIP;
                            end
                        end
                    end else begin
                        ps_pos++;
                    end
                end
            end
            PH_SKIP: begin
                ps_left--;
                if (ps_left == 32'd0) begin
                    ps_phase = PH_FRAME_HEADER;
                    ps_pos   = 4'd0;
                end
            end
            default: begin
                ps_left--;
                case (ps_sub)
                    SUB_ENCODING:    ps_sub = SUB_MIME;
                    SUB_MIME:        if (b == 8'd0) ps_sub = SUB_TYPE;
                    SUB_TYPE:        ps_sub = SUB_DESCRIPTION;
                    SUB_DESCRIPTION: if (b == 8'd0) ps_sub = SUB_PAYLOAD;
                    default:         valid = 1'b1;
                endcase
                if (ps_left == 32'd0) begin
                    done = 1'b1;
                    if (valid) begin
                        last = 1'b1;
                        oc   = OC_FOUND;
                    end else begin
                        oc = OC_EMPTY;
                    end
                end
            end
        endcase
        if (!done && at_end) begin
            done = 1'b1;
            oc   = OC_TRUNCATED;
        end
        if (done)
            restart_parser();
        r.pic_byte  = valid ? b : 8'd0;
        r.pic_valid = valid;
        r.pic_last  = last;
        r.done      = done;
        r.outcome   = oc;
        return done || valid;
    endfunction

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    function automatic int picture_len(input int mime_n, input int desc_n, input int pay_n);
        return mime_n + desc_n + pay_n + 4;
    endfunction

    // Append one byte to a file
    function automatic void put_byte(ref t_u8_q f, input logic [7:0] v);
        f = {f, v};
    endfunction

    function automatic void put_random(ref t_u8_q f, input int n);
        repeat (n) put_byte(f, 8'($urandom_range(0, 255)));
    endfunction

    // Syncsafe size; with dirty set, the ignored top bit of each size byte is random
    function automatic void put_tag_header(ref t_u8_q f, input logic [23:0] mark,
                                           input logic [7:0] ver, input logic [27:0] len,
                                           input bit dirty);
        put_byte(f, mark[23:16]);
        put_byte(f, mark[15:8]);
        put_byte(f, mark[7:0]);
        put_byte(f, ver);
        put_random(f, 2);
        for (int k = 3; k >= 0; k--)
            put_byte(f, {dirty ? 1'($urandom_range(0, 1)) : 1'b0, len[7*k +: 7]});
    endfunction

    function automatic void put_frame_header(ref t_u8_q f, input logic [31:0] id,
                                             input logic [31:0] size);
        for (int k = 3; k >= 0; k--)
            put_byte(f, id[8*k +: 8]);
        for (int k = 3; k >= 0; k--)
            put_byte(f, size[8*k +: 8]);
        put_random(f, 2);
    endfunction

    function automatic void put_picture_body(ref t_u8_q f, input int mime_n, input int desc_n,
                                             input int pay_n);
        put_byte(f, 8'($urandom_range(0, 3)));
        repeat (mime_n) put_byte(f, 8'($urandom_range(1, 255)));
        put_byte(f, 8'h00);
        put_byte(f, 8'($urandom_range(0, 20)));
        repeat (desc_n) put_byte(f, 8'($urandom_range(1, 255)));
        put_byte(f, 8'h00);
        put_random(f, pay_n);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Sender idles in bursts, only inside busy windows
    function automatic int unsigned sender_gap();
        if (quiet)
            return 0;
        if (tx_window_left == 0) begin
            tx_window_left = $urandom_range(20, 120);
            tx_window_busy = ($urandom_range(0, 2) != 0);
        end
        tx_window_left--;
        if (tx_window_busy && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 8);
        return 0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic at_end);
        int unsigned gap;
        t_pic_result r;
        gap = sender_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_file_end  <= at_end;
        do @(posedge i_clk); while (o_in_stall);
        if (parse_byte(b, at_end, r))
            expected_q = {expected_q, r};
        bytes_sent++;
    endtask

    // Send up to and including byte cut (whole file when cut is out of range)
    task automatic send_file(input t_u8_q f, input int cut);
        int last;
        last = (cut >= 0 && cut < f.size()) ? cut : f.size() - 1;
        for (int k = 0; k <= last; k++)
            send_byte(f[k], k == last);
    endtask

    // Hold off until every result is out and the pipeline has emptied
    task automatic wait_parser_idle();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back; call only while idle
    task automatic write_config(input logic [31:0] target, input logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_TARGET_ID;
        i_cfg_data  <= target;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_target_id = target;
        i_cfg_index <= CFG_PICTURE_MODE;
        i_cfg_data  <= {31'd0, mode};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_picture_mode = mode;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts and checking
    // ------------------------------------------------------------------
    initial begin
        int unsigned window_left;
        int unsigned burst_left;
        bit          window_busy;
        window_left = 0;
        burst_left  = 0;
        window_busy = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (window_left == 0) begin
                window_left = $urandom_range(30, 150);
                window_busy = ($urandom_range(0, 2) != 0);
            end
            window_left--;
            if (burst_left != 0)
                burst_left--;
            else if (!quiet && window_busy && $urandom_range(0, 4) == 0)
                burst_left = $urandom_range(1, 8);
            i_out_stall <= (burst_left != 0) && !quiet;
        end
    end

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_pic_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result: expected none, actual byte %0h outcome %0d",
                         $time, o_picture_byte, o_outcome);
            end else begin
                want = expected_q.pop_front();
                compare_field("picture_byte",  want.pic_byte,           o_picture_byte);
                compare_field("picture_valid", {7'd0, want.pic_valid},  {7'd0, o_picture_valid});
                compare_field("picture_last",  {7'd0, want.pic_last},   {7'd0, o_picture_last});
                compare_field("finished",      {7'd0, want.done},       {7'd0, o_finished});
                compare_field("outcome",       {5'd0, want.outcome},    {5'd0, o_outcome});
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Tag header verdicts, judged on the tenth byte
    task automatic test_tag_header();
        t_u8_q f;
        // bad marker
        f = {};
        put_tag_header(f, 24'h49_4434, ID3_VERSION, 28'd20, 1'b0);
        send_file(f, -1);
        // wrong version
        f = {};
        put_tag_header(f, ID3_MARK, 8'd4, 28'd20, 1'b0);
        send_file(f, -1);
        // marker wins over version when both are wrong
        f = {};
        put_tag_header(f, 24'h00_0000, 8'hFF, 28'd20, 1'b1);
        send_file(f, -1);
        // empty tag, with the masked size bits random
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd0, 1'b1);
        send_file(f, -1);
        // file ends inside the header
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd50, 1'b0);
        send_file(f, 5);
        wait_parser_idle();
    endtask

    // Picture frames under the reset settings
    task automatic test_picture_extract();
        t_u8_q f;
        // skip a text frame, then stream the picture bytes
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd100, 1'b0);
        put_frame_header(f, ID_TIT2, 32'd5);
        put_random(f, 5);
        put_frame_header(f, TARGET_ID_RESET, picture_len(3, 2, 6));
        put_picture_body(f, 3, 2, 6);
        send_file(f, -1);
        // zero-size picture frame
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd100, 1'b0);
        put_frame_header(f, TARGET_ID_RESET, 32'd0);
        send_file(f, -1);
        // fields use up the frame
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd100, 1'b0);
        put_frame_header(f, TARGET_ID_RESET, picture_len(2, 1, 0));
        put_picture_body(f, 2, 1, 0);
        send_file(f, -1);
        // frame shorter than its fields
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd100, 1'b0);
        put_frame_header(f, TARGET_ID_RESET, 32'd3);
        put_random(f, 3);
        send_file(f, -1);
        // zero-size unmatched frame, then padding
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd100, 1'b0);
        put_frame_header(f, ID_TPE1, 32'd0);
        repeat (3) put_byte(f, 8'h00);
        send_file(f, 20);
        // tag end reached by an unmatched frame header
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd13, 1'b0);
        put_frame_header(f, ID_TALB, 32'd3);
        send_file(f, -1);
        // picture frame running past the tag end
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd12, 1'b0);
        put_frame_header(f, TARGET_ID_RESET, picture_len(1, 0, 9));
        put_picture_body(f, 1, 0, 9);
        send_file(f, -1);
        // early end on a payload byte
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd100, 1'b0);
        put_frame_header(f, TARGET_ID_RESET, picture_len(0, 0, 8));
        put_picture_body(f, 0, 0, 8);
        send_file(f, f.size() - 3);
        // largest sizes: unmatched frame overruns the largest tag at once
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'hFFF_FFFF, 1'b1);
        put_frame_header(f, 32'h5858_5858, 32'hFFFF_FFFF);
        put_random(f, 4);
        send_file(f, -1);
        // largest picture frame, cut short
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'hFFF_FFFF, 1'b0);
        put_frame_header(f, TARGET_ID_RESET, 32'hFFFF_FFFF);
        put_picture_body(f, 1, 1, 6);
        send_file(f, -1);
        wait_parser_idle();
    endtask

    // Presence mode and the extreme target IDs
    task automatic test_presence_mode();
        t_u8_q f;
        write_config(ID_TIT2, 1'b0);
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd60, 1'b0);
        put_frame_header(f, ID_TPE1, 32'd4);
        put_random(f, 4);
        put_frame_header(f, ID_TIT2, 32'd7);
        send_file(f, -1);
        wait_parser_idle();

        write_config(32'hFFFF_FFFF, 1'b1);
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd40, 1'b0);
        put_frame_header(f, 32'hFFFF_FFFF, picture_len(2, 2, 5));
        put_picture_body(f, 2, 2, 5);
        send_file(f, -1);
        wait_parser_idle();

        // a zero ID can never match: its first byte reads as padding
        write_config(32'd0, 1'b0);
        f = {};
        put_tag_header(f, ID3_MARK, ID3_VERSION, 28'd40, 1'b0);
        put_frame_header(f, ID_TIT2, 32'd2);
        put_random(f, 2);
        put_byte(f, 8'h00);
        send_file(f, -1);
        wait_parser_idle();
    endtask

    task automatic send_random_file();
        t_u8_q       f;
        t_u8_q       body;
        int          mime_n;
        int          desc_n;
        int          pay_n;
        int          cut;
        logic [31:0] fid;
        logic [31:0] flen;
        logic [27:0] tag_len;
        logic [23:0] mark;
        logic [7:0]  ver;
        f    = {};
        body = {};
        // plain noise now and then
        if ($urandom_range(0, 9) == 0) begin
            put_random(f, $urandom_range(1, 24));
            send_file(f, -1);
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 4) < 2)
                fid = cfg_target_id;
            else if ($urandom_range(0, 1) == 0)
                fid = ID_TIT2;
            else
                fid = {8'($urandom_range(1, 255)), 24'($urandom)};
            if ($urandom_range(0, 39) == 0) begin
                put_frame_header(body, fid, {24'hFF_FFFF, 8'($urandom)});
                put_random(body, $urandom_range(0, 6));
            end else if (fid == cfg_target_id && cfg_picture_mode) begin
                mime_n = $urandom_range(0, 4);
                desc_n = $urandom_range(0, 3);
                pay_n  = $urandom_range(0, 10);
                flen   = picture_len(mime_n, desc_n, pay_n);
                // size that disagrees with the fields
                if ($urandom_range(0, 5) == 0)
                    flen = $urandom_range(0, flen + 3);
                put_frame_header(body, fid, flen);
                put_picture_body(body, mime_n, desc_n, pay_n);
            end else begin
                flen = $urandom_range(0, 12);
                put_frame_header(body, fid, flen);
                put_random(body, flen);
            end
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) put_byte(body, 8'h00);
        case ($urandom_range(0, 7))
            0:       tag_len = 28'd0;
            1:       tag_len = 28'($urandom_range(1, body.size() + 8));
            2:       tag_len = 28'hFFF_FFFF;
            default: tag_len = 28'(body.size());
        endcase
        mark = ID3_MARK;
        ver  = ID3_VERSION;
        if ($urandom_range(0, 15) == 0)
            mark = mark ^ (24'd1 << $urandom_range(0, 23));
        if ($urandom_range(0, 15) == 0)
            ver = 8'($urandom_range(0, 255));
        put_tag_header(f, mark, ver, tag_len, 1'($urandom_range(0, 1)));
        foreach (body[k])
            put_byte(f, body[k]);
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, f.size() - 1) : -1;
        send_file(f, cut);
    endtask

    // Random files in phases, with fresh settings between phases
    task automatic test_random_files();
        logic [31:0] target;
        while (bytes_sent < ITEM_TOTAL) begin
            wait_parser_idle();
            case ($urandom_range(0, 5))
                0:       target = TARGET_ID_RESET;
                1:       target = ID_TIT2;
                2:       target = 32'hFFFF_FFFF;
                3:       target = 32'd0;
                4:       target = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                                   8'($urandom_range(65, 90)), 8'($urandom_range(48, 57))};
                default: target = $urandom;
            endcase
            write_config(target, $urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8)) begin
                send_random_file();
                if (bytes_sent >= ITEM_TOTAL - 150)
                    quiet = 1'b1;
                if (bytes_sent >= ITEM_TOTAL)
                    break;
            end
        end
        wait_parser_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'd0;
        i_file_end  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_TARGET_ID;
        i_cfg_data  <= '0;
        bytes_sent       = 0;
        err_cnt          = 0;
        quiet            = 1'b0;
        tx_window_left   = 0;
        tx_window_busy   = 1'b0;
        cfg_target_id    = TARGET_ID_RESET;
        cfg_picture_mode = 1'b1;
        restart_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tag_header();
        test_picture_extract();
        test_presence_mode();
        test_random_files();

        if (err_cnt == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
